// ===== hdl/cds_pkg.sv =====
// ----------------------------------------------------------------------------
// cds_pkg
// shared types, codes and calendar helpers for the calendar date stepper
// ----------------------------------------------------------------------------
package cds_pkg;

  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned DIFF_W  = 22;
  localparam int unsigned CNT_IN_W = 22;
  localparam int unsigned DATE_W  = YEAR_W + MONTH_W + DAY_W;

  localparam logic [1:0] MODE_DIFF = 2'd0;
  localparam logic [1:0] MODE_ADD  = 2'd1;
  localparam logic [1:0] MODE_SUB  = 2'd2;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_INVALID = 2'd1;
  localparam logic [1:0] STATUS_RANGE   = 2'd2;

  localparam logic [YEAR_W-1:0]  YEAR_MAX = 14'd9999;
  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
  localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;
  localparam logic [DAY_W-1:0]   DAY_LAST_DEC = 5'd31;

  typedef struct packed {
    logic load;
    logic step;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic fin;
  } sts_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [DIFF_W-1:0]  diff;
    logic [1:0]         status;
  } res_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [YEAR_W-1:0] y,
                                                 input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    case (m) inside
      MONTH_FEB: len = (y[1:0] == 2'b00) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic date_valid(input logic [YEAR_W-1:0] y,
                                      input logic [MONTH_W-1:0] m,
                                      input logic [DAY_W-1:0] d);
    return (y <= YEAR_MAX) && (m >= MONTH_JAN) && (m <= MONTH_DEC) &&
           (d >= DAY_FIRST) && (d <= month_len(y, m));
  endfunction

endpackage

// ===== hdl/cds_ctrl.sv =====
// ----------------------------------------------------------------------------
// cds_ctrl
// sequencer: load a transaction, step the datapath until done, hand off result
// ----------------------------------------------------------------------------
module cds_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          out_free_i,
  input  cds_pkg::sts_t sts_i,
  output cds_pkg::cmd_t cmd_o
);
  import cds_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_RUN;
        end
      end
      ST_RUN: begin
        if (sts_i.fin) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free_i) begin
          cmd_o.publish = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hdl/cds_dp.sv =====
// ----------------------------------------------------------------------------
// cds_dp
// datapath: input checks, current and target date, day counter, one-day step
// ----------------------------------------------------------------------------
module cds_dp #(
  parameter int unsigned COUNT_WIDTH = 22
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  cds_pkg::cmd_t                    cmd_i,
  input  logic [1:0]                       mode_i,
  input  logic [cds_pkg::YEAR_W-1:0]       first_year_i,
  input  logic [cds_pkg::MONTH_W-1:0]      first_month_i,
  input  logic [cds_pkg::DAY_W-1:0]        first_day_i,
  input  logic [cds_pkg::YEAR_W-1:0]       second_year_i,
  input  logic [cds_pkg::MONTH_W-1:0]      second_month_i,
  input  logic [cds_pkg::DAY_W-1:0]        second_day_i,
  input  logic [cds_pkg::CNT_IN_W-1:0]     day_count_i,
  output cds_pkg::sts_t                    sts_o,
  output cds_pkg::res_t                    res_o
);
  import cds_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] CntMax = '1;

  logic [1:0]             mode_q;
  logic [1:0]             err_q, err_d;
  logic [YEAR_W-1:0]      y_q, ty_q;
  logic [MONTH_W-1:0]     m_q, tm_q;
  logic [DAY_W-1:0]       d_q, td_q;
  logic [COUNT_WIDTH-1:0] cnt_q;

  logic             first_ok, second_ok, too_big, first_later;
  logic             fwd, at_target, at_top, at_bottom, at_edge;
  logic [DAY_W-1:0] cur_len, prev_len;
  logic [MONTH_W-1:0] prev_month;

  assign first_ok    = date_valid(first_year_i, first_month_i, first_day_i);
  assign second_ok   = date_valid(second_year_i, second_month_i, second_day_i);
  assign too_big     = 33'(day_count_i) > 33'(CntMax);
  assign first_later = {first_year_i, first_month_i, first_day_i} >
                       {second_year_i, second_month_i, second_day_i};

  always_comb begin
    err_d = STATUS_OK;
    if ((mode_i != MODE_DIFF && mode_i != MODE_ADD && mode_i != MODE_SUB) ||
        !first_ok) begin
      err_d = STATUS_INVALID;
    end else if (mode_i == MODE_DIFF) begin
      if (!second_ok) begin
        err_d = STATUS_INVALID;
      end
    end else if (too_big) begin
      err_d = STATUS_RANGE;
    end
  end

  assign fwd        = (mode_q != MODE_SUB);
  assign at_target  = {y_q, m_q, d_q} == {ty_q, tm_q, td_q};
  assign at_top     = {y_q, m_q, d_q} == {YEAR_MAX, MONTH_DEC, DAY_LAST_DEC};
  assign at_bottom  = {y_q, m_q, d_q} == {{YEAR_W{1'b0}}, MONTH_JAN, DAY_FIRST};
  assign at_edge    = fwd ? at_top : at_bottom;
  assign cur_len    = month_len(y_q, m_q);
  assign prev_month = m_q - MONTH_JAN;
  assign prev_len   = month_len(y_q, prev_month);

  always_comb begin
    sts_o.fin = 1'b0;
    if (err_q != STATUS_OK) begin
      sts_o.fin = 1'b1;
    end else if (mode_q == MODE_DIFF) begin
      sts_o.fin = at_target || (cnt_q == CntMax);
    end else begin
      sts_o.fin = (cnt_q == '0) || at_edge;
    end
  end

  always_comb begin
    res_o = '0;
    if (err_q != STATUS_OK) begin
      res_o.status = err_q;
    end else if (mode_q == MODE_DIFF) begin
      res_o.diff = DIFF_W'(cnt_q);
    end else if (cnt_q != '0) begin
      res_o.status = STATUS_RANGE;
    end else begin
      res_o.year  = y_q;
      res_o.month = m_q;
      res_o.day   = d_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_DIFF;
      err_q  <= STATUS_OK;
      cnt_q  <= '0;
    end else if (cmd_i.load) begin
      mode_q <= mode_i;
      err_q  <= err_d;
      cnt_q  <= (mode_i == MODE_DIFF) ? '0 : COUNT_WIDTH'(day_count_i);
    end else if (cmd_i.step) begin
      cnt_q  <= (mode_q == MODE_DIFF) ? cnt_q + 1'b1 : cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      if (mode_i == MODE_DIFF && first_later) begin
        y_q  <= second_year_i;
        m_q  <= second_month_i;
        d_q  <= second_day_i;
        ty_q <= first_year_i;
        tm_q <= first_month_i;
        td_q <= first_day_i;
      end else begin
        y_q  <= first_year_i;
        m_q  <= first_month_i;
        d_q  <= first_day_i;
        ty_q <= second_year_i;
        tm_q <= second_month_i;
        td_q <= second_day_i;
      end
    end else if (cmd_i.step) begin
      if (fwd) begin
        if (d_q == cur_len) begin
          d_q <= DAY_FIRST;
          if (m_q == MONTH_DEC) begin
            m_q <= MONTH_JAN;
            y_q <= y_q + 1'b1;
          end else begin
            m_q <= m_q + 1'b1;
          end
        end else begin
          d_q <= d_q + 1'b1;
        end
      end else begin
        if (d_q == DAY_FIRST) begin
          if (m_q == MONTH_JAN) begin
            m_q <= MONTH_DEC;
            d_q <= DAY_LAST_DEC;
            y_q <= y_q - 1'b1;
          end else begin
            m_q <= prev_month;
            d_q <= prev_len;
          end
        end else begin
          d_q <= d_q - 1'b1;
        end
      end
    end
  end

endmodule

// ===== hdl/calendar_date_stepper_top.sv =====
// ----------------------------------------------------------------------------
// calendar_date_stepper_top
// date difference and day add/subtract, stepped one calendar day per cycle
//
// channel   dir  tdata                                   tuser
// s_axis    in   dates and day count (see port comment)  mode
// m_axis    out  result date and difference              status
//
// an item goes through accept, one step per day stepped, finish and hand-off;
// steps is day_count for add/subtract (fewer when the calendar edge stops it),
// the span in days (capped at 2^COUNT_WIDTH-1) for difference, zero when an
// input is rejected; the single day-step unit in cds_dp does all stepping
// reset clears the sequencer and the output valid flag; no clearing pass
// a new transaction is taken while a finished result waits in m_axis
// ----------------------------------------------------------------------------
module calendar_date_stepper_top #(
  parameter int unsigned COUNT_WIDTH = 22
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // first_year, first_month, first_day, second_year, second_month,
  // second_day, day_count, zero pad
  input  logic [71:0] s_axis_tdata_i,
  // mode
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // result_year, result_month, result_day, difference_days, zero pad
  output logic [47:0] m_axis_tdata_o,
  // status
  output logic [1:0]  m_axis_tuser_o
);
  import cds_pkg::*;

  cmd_t cmd;
  sts_t sts;
  res_t res;
  logic out_free;

  logic        out_valid_q;
  logic [47:0] out_data_q;
  logic [1:0]  out_user_q;

  assign out_free = !out_valid_q || m_axis_tready_i;

  cds_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .out_free_i (out_free),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cds_dp #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .mode_i         (s_axis_tuser_i),
    .first_year_i   (s_axis_tdata_i[13:0]),
    .first_month_i  (s_axis_tdata_i[17:14]),
    .first_day_i    (s_axis_tdata_i[22:18]),
    .second_year_i  (s_axis_tdata_i[36:23]),
    .second_month_i (s_axis_tdata_i[40:37]),
    .second_day_i   (s_axis_tdata_i[45:41]),
    .day_count_i    (s_axis_tdata_i[67:46]),
    .sts_o          (sts),
    .res_o          (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.publish) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.publish) begin
      out_data_q <= {3'b000, res.diff, res.day, res.month, res.year};
      out_user_q <= res.status;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// checks the calendar date stepper against a day-number predictor: directed
// calendar edge cases, then random valid and broken requests, with random gaps
// on both stream sides and one long output stall that backs up the input
// ----------------------------------------------------------------------------
module testbench;
  import cds_pkg::*;

  localparam logic [1:0]  MODE_UNUSED      = 2'd3;
  localparam int unsigned RANDOM_ITEMS     = 80;
  localparam int unsigned LONG_HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES     = 20;
  localparam longint      DIFF_CAP         = (longint'(1) << DIFF_W) - 1;

  typedef struct {
    logic [1:0]          mode;
    logic [YEAR_W-1:0]   first_year;
    logic [MONTH_W-1:0]  first_month;
    logic [DAY_W-1:0]    first_day;
    logic [YEAR_W-1:0]   second_year;
    logic [MONTH_W-1:0]  second_month;
    logic [DAY_W-1:0]    second_day;
    logic [CNT_IN_W-1:0] day_count;
    int unsigned         gap;
  } date_request_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [71:0] s_axis_tdata_i;
  logic [1:0]  s_axis_tuser_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [47:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;

  date_request_t pending_requests[$];
  res_t          expected_results[$];
  date_request_t offered_request;
  res_t          accepted_expect;
  res_t          result_expect;

  logic        s_taken;
  logic        m_taken;
  logic        offer_next;
  int unsigned idle_left;
  int unsigned stall_left;
  bit          long_hold_done;
  int unsigned total_items;
  int unsigned accepted_items;
  int unsigned results_seen;
  int unsigned error_count;
  int unsigned diff_items, add_items, sub_items, invalid_items, range_items;

  calendar_date_stepper_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  function automatic int unsigned month_days(int unsigned y, int unsigned m);
    case (m)
      2: return (y % 4 == 0) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default: return 31;
    endcase
  endfunction

  function automatic bit date_good(int unsigned y, int unsigned m, int unsigned d);
    return (y <= YEAR_MAX) && (m >= 1) && (m <= 12) && (d >= 1) &&
           (d <= month_days(y, m));
  endfunction

  // days since 0000-01-01
  function automatic longint day_number(int unsigned y, int unsigned m, int unsigned d);
    longint      n;
    int unsigned k;
    n = 365 * longint'(y) + longint'((y + 3) / 4);
    for (k = 1; k < m; k++) n += longint'(month_days(y, k));
    return n + longint'(d) - 1;
  endfunction

  function automatic res_t predict_date_result(date_request_t q);
    res_t        r;
    longint      a;
    longint      b;
    longint      t;
    longint      span;
    int unsigned yy;
    int unsigned mm;
    int unsigned rest;
    r = '0;
    if (q.mode > MODE_SUB ||
        !date_good(32'(q.first_year), 32'(q.first_month), 32'(q.first_day))) begin
      r.status = STATUS_INVALID;
      return r;
    end
    a = day_number(32'(q.first_year), 32'(q.first_month), 32'(q.first_day));
    if (q.mode == MODE_DIFF) begin
      if (!date_good(32'(q.second_year), 32'(q.second_month), 32'(q.second_day))) begin
        r.status = STATUS_INVALID;
        return r;
      end
      b = day_number(32'(q.second_year), 32'(q.second_month), 32'(q.second_day));
      span = (a >= b) ? a - b : b - a;
      if (span > DIFF_CAP) span = DIFF_CAP;
      r.diff = span[DIFF_W-1:0];
      r.status = STATUS_OK;
      return r;
    end
    t = (q.mode == MODE_ADD) ? a + longint'(q.day_count) : a - longint'(q.day_count);
    if (t < 0 || t > day_number(32'(YEAR_MAX), 32'(MONTH_DEC), 32'(DAY_LAST_DEC))) begin
      r.status = STATUS_RANGE;
      return r;
    end
    // four-year cycles of 1461 days, leap year first
    yy = int'(t / 1461) * 4;
    rest = int'(t % 1461);
    if (rest >= 366) begin
      rest -= 366;
      yy += 1 + rest / 365;
      rest = rest % 365;
    end
    mm = 1;
    while (mm < 12 && rest >= month_days(yy, mm)) begin
      rest -= month_days(yy, mm);
      mm++;
    end
    r.year = yy[YEAR_W-1:0];
    r.month = mm[MONTH_W-1:0];
    r.day = rest[DAY_W-1:0] + 1'b1;
    r.status = STATUS_OK;
    return r;
  endfunction

  function automatic logic [71:0] pack_request(date_request_t q);
    return {4'b0, q.day_count, q.second_day, q.second_month, q.second_year,
            q.first_day, q.first_month, q.first_year};
  endfunction

  function automatic int unsigned pick_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic date_request_t make_request(logic [1:0] mode,
      int unsigned y1, int unsigned m1, int unsigned d1,
      int unsigned y2, int unsigned m2, int unsigned d2, int unsigned count);
    date_request_t q;
    q.mode = mode;
    q.first_year = YEAR_W'(y1);
    q.first_month = MONTH_W'(m1);
    q.first_day = DAY_W'(d1);
    q.second_year = YEAR_W'(y2);
    q.second_month = MONTH_W'(m2);
    q.second_day = DAY_W'(d2);
    q.day_count = CNT_IN_W'(count);
    q.gap = pick_idle();
    return q;
  endfunction

  // quick requests keep spans and counts short so the block turns them around fast
  function automatic date_request_t random_request(bit quick);
    date_request_t q;
    int unsigned   sel;
    int unsigned   y;
    int            shift;
    int            sy;
    q.gap = pick_idle();
    q.mode = 2'($urandom_range(MODE_DIFF, MODE_SUB));
    sel = $urandom_range(0, 9);
    if (sel == 0) y = $urandom_range(0, 3);
    else if (sel == 1) y = $urandom_range(9996, 9999);
    else y = $urandom_range(0, 9999);
    q.first_year = YEAR_W'(y);
    q.first_month = MONTH_W'($urandom_range(1, 12));
    q.first_day = DAY_W'($urandom_range(1, month_days(y, 32'(q.first_month))));
    if (quick) begin
      q.second_year = q.first_year;
      q.second_month = q.first_month;
    end else begin
      shift = $urandom_range(0, 4);
      sy = int'(y) + shift - 2;
      if (sy < 0) sy = 0;
      if (sy > 9999) sy = 9999;
      q.second_year = YEAR_W'(sy);
      q.second_month = MONTH_W'($urandom_range(1, 12));
    end
    q.second_day = DAY_W'($urandom_range(1, month_days(32'(q.second_year),
                                                        32'(q.second_month))));
    sel = $urandom_range(0, 99);
    if (quick) q.day_count = CNT_IN_W'($urandom_range(0, 60));
    else if (sel < 80) q.day_count = CNT_IN_W'($urandom_range(0, 1500));
    else if (sel < 95) q.day_count = CNT_IN_W'($urandom_range(0, 20000));
    else q.day_count = CNT_IN_W'($urandom_range(0, 40));
    // broken requests
    if ($urandom_range(0, 99) < 12) begin
      case ($urandom_range(0, 5))
        0: q.first_year = YEAR_W'($urandom_range(10000, 16383));
        1: q.first_month = MONTH_W'($urandom_range(13, 16) % 16);
        2: q.first_day = '0;
        3: begin
          if (month_days(32'(q.first_year), 32'(q.first_month)) < 31)
            q.first_day = DAY_W'($urandom_range(
                month_days(32'(q.first_year), 32'(q.first_month)) + 1, 31));
          else
            q.first_day = '0;
        end
        4: q.mode = MODE_UNUSED;
        default: q.second_month = '0;
      endcase
    end
    return q;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endtask

  // input side: prediction on every accepted transaction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_taken <= 1'b0;
    end else begin
      s_taken <= s_axis_tvalid_i && s_axis_tready_o;
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        accepted_expect = predict_date_result(offered_request);
        expected_results.push_back(accepted_expect);
        accepted_items++;
        if (accepted_expect.status == STATUS_INVALID) invalid_items++;
        else if (accepted_expect.status == STATUS_RANGE) range_items++;
        else if (offered_request.mode == MODE_DIFF) diff_items++;
        else if (offered_request.mode == MODE_ADD) add_items++;
        else sub_items++;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      offer_next = s_axis_tvalid_i && !s_taken;
      if (!offer_next) begin
        if (idle_left > 0) begin
          idle_left--;
        end else if (pending_requests.size() != 0) begin
          offered_request = pending_requests.pop_front();
          idle_left = offered_request.gap;
          s_axis_tdata_i <= pack_request(offered_request);
          s_axis_tuser_i <= offered_request.mode;
          offer_next = 1'b1;
        end
      end
      s_axis_tvalid_i <= offer_next;
    end
  end

  // output side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_taken <= 1'b0;
    end else begin
      m_taken <= m_axis_tvalid_o && m_axis_tready_i;
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result transaction with no request outstanding");
          error_count++;
        end else begin
          result_expect = expected_results.pop_front();
          check_field("result_year", 32'(result_expect.year), 32'(m_axis_tdata_o[13:0]));
          check_field("result_month", 32'(result_expect.month),
                      32'(m_axis_tdata_o[17:14]));
          check_field("result_day", 32'(result_expect.day), 32'(m_axis_tdata_o[22:18]));
          check_field("difference_days", 32'(result_expect.diff),
                      32'(m_axis_tdata_o[44:23]));
          check_field("status", 32'(result_expect.status), 32'(m_axis_tuser_o));
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (m_taken) stall_left = (results_seen >= 70 && results_seen < 90) ? 0 : pick_idle();
      // one long hold-off so the block backs up and drops s_axis_tready
      if (!long_hold_done && results_seen >= 50) begin
        stall_left = LONG_HOLD_CYCLES;
        long_hold_done = 1'b1;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  initial begin
    date_request_t q;
    int unsigned   i;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    s_axis_tuser_i = '0;
    m_axis_tready_i = 1'b0;

    pending_requests.push_back(make_request(MODE_DIFF, 0, 1, 1, 9999, 12, 31, 0));
    pending_requests.push_back(make_request(MODE_DIFF, 2024, 2, 29, 2024, 2, 29, 0));
    pending_requests.push_back(make_request(MODE_DIFF, 2001, 3, 1, 2000, 2, 28, 0));
    pending_requests.push_back(make_request(MODE_DIFF, 2000, 5, 5, 2001, 2, 29, 0));
    pending_requests.push_back(make_request(MODE_DIFF, 1999, 1, 1, 16383, 1, 1, 0));
    pending_requests.push_back(make_request(MODE_DIFF, 1999, 1, 1, 1999, 0, 1, 0));
    pending_requests.push_back(make_request(MODE_ADD, 0, 1, 1, 0, 0, 0, 32'h003F_FFFF));
    pending_requests.push_back(make_request(MODE_ADD, 9999, 12, 31, 0, 0, 0, 0));
    pending_requests.push_back(make_request(MODE_ADD, 9999, 12, 31, 0, 0, 0, 1));
    pending_requests.push_back(make_request(MODE_SUB, 0, 1, 1, 0, 0, 0, 1));
    pending_requests.push_back(make_request(MODE_SUB, 0, 3, 1, 0, 0, 0, 1));
    pending_requests.push_back(make_request(MODE_ADD, 4, 2, 28, 0, 0, 0, 1));
    pending_requests.push_back(make_request(MODE_ADD, 3, 2, 28, 0, 0, 0, 1));
    pending_requests.push_back(make_request(MODE_ADD, 1999, 12, 31, 0, 0, 0, 1));
    pending_requests.push_back(make_request(MODE_SUB, 2000, 1, 1, 0, 0, 0, 1461));
    pending_requests.push_back(make_request(MODE_ADD, 16383, 1, 1, 0, 0, 0, 5));
    pending_requests.push_back(make_request(MODE_ADD, 2000, 0, 1, 0, 0, 0, 3));
    pending_requests.push_back(make_request(MODE_SUB, 2000, 15, 1, 0, 0, 0, 3));
    pending_requests.push_back(make_request(MODE_ADD, 2000, 13, 10, 0, 0, 0, 3));
    pending_requests.push_back(make_request(MODE_SUB, 2000, 6, 0, 0, 0, 0, 3));
    pending_requests.push_back(make_request(MODE_ADD, 2000, 4, 31, 0, 0, 0, 3));
    pending_requests.push_back(make_request(MODE_ADD, 1, 2, 29, 0, 0, 0, 3));
    pending_requests.push_back(make_request(MODE_UNUSED, 2000, 1, 1, 2000, 1, 2, 3));

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      q = random_request(i >= 20 && i < 60);
      if (i >= 20 && i < 60) q.gap = 0;
      pending_requests.push_back(q);
    end
    total_items = pending_requests.size();

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (accepted_items < total_items || expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("checked %0d date transactions: %0d difference, %0d add, %0d subtract",
             accepted_items, diff_items, add_items, sub_items);
    $display("rejected: %0d invalid date or mode, %0d out of range; long output stall: %0d",
             invalid_items, range_items, long_hold_done);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
